>>> hw/rtl/dws_pkg.sv
// Package with the word types and fixed constants of the differential wheel sync unit.
`default_nettype none

package dws_pkg;

  // Servo pulse widths for stop and the two mode limits.
  localparam logic [12:0] SPEED_STOP    = 13'd4500;
  localparam logic [12:0] SPEED_FWD_MAX = 13'd5700;
  localparam logic [12:0] SPEED_REV_MAX = 13'd3300;

  // Proportional gain as a left shift amount (gain of four).
  localparam int unsigned GAIN_SHIFT = 2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BASE_SPEED     = 2'd0,
    CFG_TARGET_TICKS   = 2'd1,
    CFG_STOP_AT_TARGET = 2'd2
  } cfg_idx_e;

  // One input word: new encoder pulses and the clear flag.
  typedef struct packed {
    logic [7:0] left_pulses;
    logic [7:0] right_pulses;
    logic       clear_totals;
  } in_word_t;

  // One result word: drive commands, target flag and running totals.
  typedef struct packed {
    logic [12:0] left_drive;
    logic [12:0] right_drive;
    logic        reached;
    logic [23:0] left_count;
    logic [23:0] right_count;
  } out_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/differential_wheel_sync_unit.sv
// Top level of the differential wheel sync unit: encoder totals and balancing drive control.
//
// Usage: each input word carries the left and right encoder pulses counted since the
// previous word and a flag that zeroes both running totals before they are added.
// For every accepted input word the block returns exactly one result word with the two
// servo drive commands, the reached flag and the low 24 bits of both totals.
// Both channels use valid and stall; a word moves at a clock edge with valid high and
// stall low. The configuration port writes base speed, target ticks and the stop enable
// at any edge with cfg_we_i high; the user must write it only while no word is in flight,
// and the block itself does not enforce this. An accepted word passes the input register
// and the arithmetic into the result register before it is shown on the output.
// Throughput: one word per cycle while out_stall_i is low; the totals are updated as each
// word passes from the input register to the result register, so back-to-back words chain
// at full rate. When the receiver stalls, the result word holds and the input register still
// takes one more word; input stall rises only when both registers are full.
// Reset clears both totals, the valid flags and the configuration to its reset values
// (base speed 4500, target zero, stop disabled).
`default_nettype none

module differential_wheel_sync_unit #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dws_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dws_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [23:0]        cfg_wdata_i
);

  import dws_pkg::*;

  // Signed width that holds base plus or minus four times the total difference.
  localparam int unsigned SW = COUNT_WIDTH + 4;

  localparam logic signed [SW-1:0] STOP_S    = $signed(SW'(SPEED_STOP));
  localparam logic signed [SW-1:0] FWD_MAX_S = $signed(SW'(SPEED_FWD_MAX));
  localparam logic signed [SW-1:0] REV_MAX_S = $signed(SW'(SPEED_REV_MAX));
  localparam logic [COUNT_WIDTH-1:0] TOTAL_MAX = {COUNT_WIDTH{1'b1}};

  // Clamp a signed drive value into [lo, hi] and return its pulse width.
  function automatic logic [12:0] clamp_drive(logic signed [SW-1:0] v,
                                              logic signed [SW-1:0] lo,
                                              logic signed [SW-1:0] hi);
    logic signed [SW-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[12:0];
  endfunction

  // Configuration registers.
  logic [12:0] base_speed_q;
  logic [23:0] target_ticks_q;
  logic        stop_at_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q     <= SPEED_STOP;
      target_ticks_q   <= '0;
      stop_at_target_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_SPEED:     base_speed_q     <= cfg_wdata_i[12:0];
        CFG_TARGET_TICKS:   target_ticks_q   <= cfg_wdata_i;
        CFG_STOP_AT_TARGET: stop_at_target_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Handshake of the two register stages.
  logic     in_valid_q;
  in_word_t in_word_q;
  logic     out_valid_q;
  logic     out_adv;
  logic     in_adv;
  logic     fire;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;
  assign in_adv     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      in_word_q <= in_word_i;
    end
  end

  // Running totals: optional clear, then a saturating add of the new pulses.
  logic [COUNT_WIDTH-1:0] left_total_q, left_total_d;
  logic [COUNT_WIDTH-1:0] right_total_q, right_total_d;
  logic [COUNT_WIDTH-1:0] left_start, right_start;
  logic [COUNT_WIDTH:0]   left_sum, right_sum;

  always_comb begin
    left_start  = in_word_q.clear_totals ? '0 : left_total_q;
    right_start = in_word_q.clear_totals ? '0 : right_total_q;
    left_sum    = {1'b0, left_start} + (COUNT_WIDTH + 1)'(in_word_q.left_pulses);
    right_sum   = {1'b0, right_start} + (COUNT_WIDTH + 1)'(in_word_q.right_pulses);
    left_total_d  = left_sum[COUNT_WIDTH] ? TOTAL_MAX : left_sum[COUNT_WIDTH-1:0];
    right_total_d = right_sum[COUNT_WIDTH] ? TOTAL_MAX : right_sum[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_total_q  <= '0;
      right_total_q <= '0;
    end else if (fire) begin
      left_total_q  <= left_total_d;
      right_total_q <= right_total_d;
    end
  end

  // Target compare, balancing term and mode dependent clamps.
  logic                   reached;
  logic signed [COUNT_WIDTH:0] delta;
  logic signed [SW-1:0]   corr;
  logic signed [SW-1:0]   base_s;
  logic signed [SW-1:0]   sum_pos, sum_neg;
  out_word_t              out_word_d;

  always_comb begin
    reached = (32'(left_total_d) >= 32'(target_ticks_q)) ||
              (32'(right_total_d) >= 32'(target_ticks_q));
    delta   = $signed({1'b0, left_total_d}) - $signed({1'b0, right_total_d});
    corr    = SW'(delta) <<< GAIN_SHIFT;
    base_s  = $signed(SW'(base_speed_q));
    sum_pos = base_s + corr;
    sum_neg = base_s - corr;

    if (stop_at_target_q && reached) begin
      out_word_d.left_drive  = SPEED_STOP;
      out_word_d.right_drive = SPEED_STOP;
    end else if (base_s > STOP_S) begin
      out_word_d.left_drive  = clamp_drive(sum_pos, STOP_S, FWD_MAX_S);
      out_word_d.right_drive = clamp_drive(sum_neg, STOP_S, FWD_MAX_S);
    end else begin
      out_word_d.left_drive  = clamp_drive(sum_neg, REV_MAX_S, STOP_S);
      out_word_d.right_drive = clamp_drive(sum_pos, REV_MAX_S, STOP_S);
    end
    out_word_d.reached     = reached;
    out_word_d.left_count  = 24'(32'(left_total_d));
    out_word_d.right_count = 24'(32'(right_total_d));
  end

  // Result register.
  out_word_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

>>> hw/rtl/dws_checker.sv
// Port level checker of the differential wheel sync unit and its bind statement.
`default_nettype none

module dws_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire dws_pkg::out_word_t out_word_o
);

  import dws_pkg::*;

  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // The input side only stalls while a result word is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // Both drive commands stay inside the servo range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.left_drive >= SPEED_REV_MAX) &&
                    (out_word_o.left_drive <= SPEED_FWD_MAX) &&
                    (out_word_o.right_drive >= SPEED_REV_MAX) &&
                    (out_word_o.right_drive <= SPEED_FWD_MAX))
    else $error("drive command out of range");

  // Both wheels are always driven in the same direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.left_drive >= SPEED_STOP) &&
                     (out_word_o.right_drive >= SPEED_STOP)) ||
                    ((out_word_o.left_drive <= SPEED_STOP) &&
                     (out_word_o.right_drive <= SPEED_STOP)))
    else $error("wheels driven in opposite directions");

endmodule

bind differential_wheel_sync_unit dws_checker u_dws_checker (.*);

`default_nettype wire
